[rtl/slp_pkg.sv]
// Package for the script token lexer: lexer modes, token and event codes,
// byte constants and the result item type.
// No dependencies.
package slp_pkg;

    // lexer mode held between input items
    typedef enum logic [2:0] {
        MODE_SKIP    = 3'd0,
        MODE_SLASH   = 3'd1,
        MODE_COMMENT = 3'd2,
        MODE_IDENT   = 3'd3,
        MODE_STRING  = 3'd4,
        MODE_ESCAPE  = 3'd5
    } mode_t;

    // token type codes
    localparam logic [3:0] TT_IDENT   = 4'd0;
    localparam logic [3:0] TT_STRING  = 4'd1;
    localparam logic [3:0] TT_LPAREN  = 4'd2;
    localparam logic [3:0] TT_RPAREN  = 4'd3;
    localparam logic [3:0] TT_LBRACE  = 4'd4;
    localparam logic [3:0] TT_RBRACE  = 4'd5;
    localparam logic [3:0] TT_LBRACK  = 4'd6;
    localparam logic [3:0] TT_RBRACK  = 4'd7;
    localparam logic [3:0] TT_HYPHEN  = 4'd8;
    localparam logic [3:0] TT_COMMA   = 4'd9;
    localparam logic [3:0] TT_END     = 4'd10;

    // event codes
    localparam logic [2:0] EV_OPEN    = 3'd0;
    localparam logic [2:0] EV_TEXT    = 3'd1;
    localparam logic [2:0] EV_CLOSE   = 3'd2;
    localparam logic [2:0] EV_DISCARD = 3'd3;
    localparam logic [2:0] EV_SINGLE  = 3'd4;

    // source byte values
    localparam logic [7:0] CH_EOF     = 8'h00;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_HYPHEN  = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    // result queue geometry
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // one result item
    typedef struct packed {
        logic [3:0] token_type;
        logic [2:0] event_res;
        logic [7:0] text_byte;
        logic       last_of_run;
    } res_t;

    // decoder output for one input byte
    typedef struct packed {
        logic [1:0] count;
        res_t       res0;
        res_t       res1;
        mode_t      next_mode;
    } dec_t;

    // queue status seen by the top level
    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              room;
    } qstat_t;

    // ascii letter test
    function automatic logic is_letter(input logic [7:0] b);
        return ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) ||
               ((b >= CH_LOWER_A) && (b <= CH_LOWER_Z));
    endfunction

    // single-token type, TT_IDENT when the byte is none of them
    function automatic logic [3:0] single_type(input logic [7:0] b);
        logic [3:0] t;
        t = TT_IDENT;
        case (b)
            CH_LPAREN: t = TT_LPAREN;
            CH_RPAREN: t = TT_RPAREN;
            CH_LBRACE: t = TT_LBRACE;
            CH_RBRACE: t = TT_RBRACE;
            CH_LBRACK: t = TT_LBRACK;
            CH_RBRACK: t = TT_RBRACK;
            CH_HYPHEN: t = TT_HYPHEN;
            CH_COMMA:  t = TT_COMMA;
            default:   t = TT_IDENT;
        endcase
        return t;
    endfunction

    // build a result with last_of_run cleared
    function automatic res_t mk_res(input logic [3:0] tt, input logic [2:0] ev,
                                    input logic [7:0] b);
        res_t r;
        r.token_type  = tt;
        r.event_res   = ev;
        r.text_byte   = (ev == EV_TEXT) ? b : 8'h00;
        r.last_of_run = 1'b0;
        return r;
    endfunction

endpackage

[rtl/script_token_lexer_unit.sv]
// Top level of the script token lexer: input register, lexer decode and
// result queue. Depends on slp_pkg, slp_lex_decode and slp_result_queue.
//
//   channel   direction   handshake              payload
//   in        into block  in_valid / in_stall    data_byte
//   out       from block  out_valid / out_stall  token_type, event_res,
//                                                text_byte, last_of_run
//
// A byte sits in the input register, is decoded there and its 0, 1 or 2
// results land in a four-entry queue. One byte per cycle is taken while
// results stay at one or fewer per byte and the output does not stall; two
// results of one byte leave one at a time through the queue's single output port.
// The first result is offered after the input register and the queue write.
// Reset empties the input register and queue and puts the lexer between tokens.
// A stall on the output backs the queue up; input stalls once the input
// register holds a byte and the queue has no room for two more items.
module script_token_lexer_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] token_type,
    output logic [2:0] event_res,
    output logic [7:0] text_byte,
    output logic       last_of_run
);

    logic            in_valid_reg;
    logic [7:0]      in_byte_reg;
    slp_pkg::mode_t  mode_reg;
    slp_pkg::dec_t   dec;
    slp_pkg::res_t   head;
    slp_pkg::qstat_t qstat;
    logic            advance;
    logic            in_take;
    logic            pop;

    // input register moves on when the queue can take two items
    assign advance  = in_valid_reg && qstat.room;
    assign in_stall = in_valid_reg && !qstat.room;
    assign in_take  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            mode_reg     <= slp_pkg::MODE_SKIP;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;
            if (advance)
                mode_reg <= dec.next_mode;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= data_byte;
    end

    // lexer step for the held byte
    slp_lex_decode u_decode
    (
        .mode    (mode_reg),
        .byte_in (in_byte_reg),
        .dec     (dec)
    );

    // result queue
    slp_result_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (advance ? dec.count : 2'd0),
        .push_res0  (dec.res0),
        .push_res1  (dec.res1),
        .pop        (pop),
        .head       (head),
        .stat       (qstat)
    );

    // output channel
    assign out_valid   = (qstat.count != '0);
    assign pop         = out_valid && !out_stall;
    assign token_type  = head.token_type;
    assign event_res   = head.event_res;
    assign text_byte   = head.text_byte;
    assign last_of_run = head.last_of_run;

`ifndef SYNTH
    // queue never overfills
    assert property (@(posedge clk) disable iff (!rst_n)
        qstat.count <= slp_pkg::QCNT_W'(slp_pkg::QDEPTH))
        else $error("result queue overflow");

    // a full input register with no queue room must hold the input
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !qstat.room |=> in_valid_reg && $stable(in_byte_reg))
        else $error("held byte lost while queue full");

    // the end token is always the last result of its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_type == slp_pkg::TT_END |-> last_of_run)
        else $error("end token not last of run");

    // text byte is zero on every event but a text byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_res != slp_pkg::EV_TEXT |-> text_byte == 8'h00)
        else $error("stray text byte");
`endif

endmodule

[rtl/slp_lex_decode.sv]
// Combinational lexer step: current mode and one source byte in, up to two
// result items and the next mode out.
// Depends on slp_pkg.
module slp_lex_decode
(
    input  slp_pkg::mode_t mode,
    input  logic [7:0]     byte_in,
    output slp_pkg::dec_t  dec
);

    // handling of the byte as if between tokens
    logic [1:0]     bw_count;
    slp_pkg::res_t  bw_res0;
    slp_pkg::res_t  bw_res1;
    slp_pkg::mode_t bw_mode;
    logic [3:0]     st;

    assign st = slp_pkg::single_type(byte_in);

    always_comb
    begin
        bw_count = 2'd0;
        bw_res0  = slp_pkg::mk_res(slp_pkg::TT_IDENT, slp_pkg::EV_OPEN, 8'h00);
        bw_res1  = slp_pkg::mk_res(slp_pkg::TT_IDENT, slp_pkg::EV_TEXT, byte_in);
        bw_mode  = slp_pkg::MODE_SKIP;
        if (st != slp_pkg::TT_IDENT)
        begin
            bw_count = 2'd1;
            bw_res0  = slp_pkg::mk_res(st, slp_pkg::EV_SINGLE, 8'h00);
        end
        else if (byte_in == slp_pkg::CH_QUOTE)
        begin
            bw_count = 2'd1;
            bw_res0  = slp_pkg::mk_res(slp_pkg::TT_STRING, slp_pkg::EV_OPEN, 8'h00);
            bw_mode  = slp_pkg::MODE_STRING;
        end
        else if (slp_pkg::is_letter(byte_in))
        begin
            bw_count = 2'd2;
            bw_mode  = slp_pkg::MODE_IDENT;
        end
        else if (byte_in == slp_pkg::CH_SLASH)
        begin
            bw_mode = slp_pkg::MODE_SLASH;
        end
    end

    // main mode decode
    always_comb
    begin
        dec.count     = 2'd0;
        dec.res0      = bw_res0;
        dec.res1      = bw_res1;
        dec.next_mode = mode;
        if (byte_in == slp_pkg::CH_EOF)
        begin
            dec.next_mode = slp_pkg::MODE_SKIP;
            dec.res1 = slp_pkg::mk_res(slp_pkg::TT_END, slp_pkg::EV_SINGLE, 8'h00);
            if (mode == slp_pkg::MODE_IDENT)
            begin
                dec.count = 2'd2;
                dec.res0  = slp_pkg::mk_res(slp_pkg::TT_IDENT, slp_pkg::EV_DISCARD, 8'h00);
            end
            else if (mode == slp_pkg::MODE_STRING || mode == slp_pkg::MODE_ESCAPE)
            begin
                dec.count = 2'd2;
                dec.res0  = slp_pkg::mk_res(slp_pkg::TT_STRING, slp_pkg::EV_DISCARD,
                                            8'h00);
            end
            else
            begin
                dec.count = 2'd1;
                dec.res0  = dec.res1;
            end
        end
        else
        begin
            unique case (mode)
                slp_pkg::MODE_SLASH:
                begin
                    if (byte_in == slp_pkg::CH_SLASH)
                    begin
                        dec.next_mode = slp_pkg::MODE_COMMENT;
                    end
                    else
                    begin
                        dec.count     = bw_count;
                        dec.next_mode = bw_mode;
                    end
                end
                slp_pkg::MODE_COMMENT:
                begin
                    if (byte_in == slp_pkg::CH_NL)
                        dec.next_mode = slp_pkg::MODE_SKIP;
                end
                slp_pkg::MODE_IDENT:
                begin
                    if (slp_pkg::is_letter(byte_in))
                    begin
                        dec.count = 2'd1;
                        dec.res0  = slp_pkg::mk_res(slp_pkg::TT_IDENT, slp_pkg::EV_TEXT,
                                                    byte_in);
                    end
                    else
                    begin
                        // close kept, then the byte is handled anew (at most one more)
                        dec.count     = bw_count + 2'd1;
                        dec.res0      = slp_pkg::mk_res(slp_pkg::TT_IDENT,
                                                        slp_pkg::EV_CLOSE, 8'h00);
                        dec.res1      = bw_res0;
                        dec.next_mode = bw_mode;
                    end
                end
                slp_pkg::MODE_STRING:
                begin
                    if (byte_in == slp_pkg::CH_QUOTE)
                    begin
                        dec.count     = 2'd1;
                        dec.res0      = slp_pkg::mk_res(slp_pkg::TT_STRING,
                                                        slp_pkg::EV_CLOSE, 8'h00);
                        dec.next_mode = slp_pkg::MODE_SKIP;
                    end
                    else if (byte_in == slp_pkg::CH_BSLASH)
                    begin
                        dec.next_mode = slp_pkg::MODE_ESCAPE;
                    end
                    else
                    begin
                        dec.count = 2'd1;
                        dec.res0  = slp_pkg::mk_res(slp_pkg::TT_STRING, slp_pkg::EV_TEXT,
                                                    byte_in);
                    end
                end
                slp_pkg::MODE_ESCAPE:
                begin
                    dec.count     = 2'd1;
                    dec.res0      = slp_pkg::mk_res(slp_pkg::TT_STRING, slp_pkg::EV_TEXT,
                                                    byte_in);
                    dec.next_mode = slp_pkg::MODE_STRING;
                end
                default:
                begin
                    dec.count     = bw_count;
                    dec.next_mode = bw_mode;
                end
            endcase
        end

        // mark the final result of this byte
        if (dec.count == 2'd1)
            dec.res0.last_of_run = 1'b1;
        if (dec.count == 2'd2)
            dec.res1.last_of_run = 1'b1;
    end

endmodule

[rtl/slp_result_queue.sv]
// Small result queue: takes up to two result items per cycle, delivers one
// per cycle on the output channel while the output does not stall.
// Depends on slp_pkg.
module slp_result_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [1:0]      push_count,
    input  slp_pkg::res_t   push_res0,
    input  slp_pkg::res_t   push_res1,
    input  logic            pop,
    output slp_pkg::res_t   head,
    output slp_pkg::qstat_t stat
);

    slp_pkg::res_t                 entry_reg [slp_pkg::QDEPTH];
    logic [slp_pkg::QPTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [slp_pkg::QPTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [slp_pkg::QCNT_W-1:0]    count_reg, count_next;
    logic [slp_pkg::QPTR_W-1:0]    wr_ptr_second;

    assign wr_ptr_second = wr_ptr_reg + slp_pkg::QPTR_W'(1);

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + slp_pkg::QPTR_W'(push_count);
        rd_ptr_next = rd_ptr_reg + slp_pkg::QPTR_W'(pop);
        count_next  = count_reg + slp_pkg::QCNT_W'(push_count)
                      - slp_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            entry_reg[wr_ptr_reg] <= push_res0;
        if (push_count == 2'd2)
            entry_reg[wr_ptr_second] <= push_res1;
    end

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.count = count_reg;
    // room for two more items regardless of this cycle's pop
    assign stat.room  = (count_reg <= slp_pkg::QCNT_W'(slp_pkg::QDEPTH - 2));

endmodule
